### src/rvid_pkg.sv
package rvid_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned ImmWidth   = 32;

  // Major opcode, instruction bits 6..2
  typedef enum logic [4:0] {
    OP_LOAD   = 5'b00000,
    OP_ALUI   = 5'b00100,
    OP_AUIPC  = 5'b00101,
    OP_STORE  = 5'b01000,
    OP_ALUR   = 5'b01100,
    OP_LUI    = 5'b01101,
    OP_BRANCH = 5'b11000,
    OP_JALR   = 5'b11001,
    OP_JAL    = 5'b11011
  } opcode_t;

  typedef enum logic [2:0] {
    F3_ADD = 3'b000,
    F3_SLL = 3'b001,
    F3_SUB = 3'b010,
    F3_XOR = 3'b100,
    F3_SR  = 3'b101,
    F3_OR  = 3'b110,
    F3_AND = 3'b111
  } funct3_t;

  localparam logic [2:0] F3_BEQ = 3'b000;
  localparam logic [2:0] F3_BLT = 3'b100;
  localparam logic [2:0] F3_MUL = 3'b000;
  localparam logic [2:0] F3_DIV = 3'b100;
  localparam logic [2:0] F3_REM = 3'b110;

  typedef enum logic [2:0] {
    IMM_NONE = 3'd0,
    IMM_I    = 3'd1,
    IMM_S    = 3'd2,
    IMM_B    = 3'd3,
    IMM_J    = 3'd4,
    IMM_U    = 3'd5
  } imm_kind_t;

  typedef enum logic [1:0] {
    CLASS_R   = 2'd0,
    CLASS_I   = 2'd1,
    CLASS_ADD = 2'd2,
    CLASS_SUB = 2'd3
  } alu_class_t;

  typedef enum logic [1:0] {
    BR_NONE = 2'd0,
    BR_BEQ  = 2'd1,
    BR_BLT  = 2'd2
  } branch_kind_t;

  typedef enum logic [1:0] {
    JMP_NONE = 2'd0,
    JMP_JAL  = 2'd1,
    JMP_JALR = 2'd2
  } jump_kind_t;

  typedef enum logic [3:0] {
    ALU_ADD = 4'd0,
    ALU_SUB = 4'd1,
    ALU_MUL = 4'd2,
    ALU_DIV = 4'd3,
    ALU_REM = 4'd4,
    ALU_XOR = 4'd5,
    ALU_OR  = 4'd6,
    ALU_AND = 4'd7,
    ALU_SLL = 4'd8,
    ALU_SR  = 4'd9
  } alu_select_t;

  localparam logic [ImmWidth-1:0] ImmNone = {1'b1, {(ImmWidth-1){1'b0}}};

  typedef struct packed {
    logic                       operand_one_is_pc;
    logic                       operand_two_is_imm;
    imm_kind_t                  imm_kind;
    alu_class_t                 alu_class;
    logic                       reads_registers;
    logic                       writes_register;
    logic                       reads_memory;
    logic                       writes_memory;
    branch_kind_t               branch_kind;
    jump_kind_t                 jump_kind;
    alu_select_t                alu_select;
    logic signed [ImmWidth-1:0] immediate;
  } decode_t;

endpackage

### src/riscv_instruction_decoder_unit.sv
// RV32IM instruction decoder. Each request carries one 32-bit instruction
// word; each result is the full control word for it: operand selects,
// immediate kind and sign-extended immediate (0x80000000 when the format has
// none), ALU class and function (including mul, div and rem), register and
// memory enables, and branch and jump kinds. The block holds no architectural
// state. An accepted request is held in the input register, and its
// control word then in the result register. The path is one input register,
// one level of decode logic and one result register. Throughput is one
// instruction per cycle; both stages advance together whenever the result
// register is empty or being drained, so out_ready stalls ripple straight
// back to in_ready. Opcodes outside the supported set decode as a U-type
// forced add that reads and writes registers. A branch whose funct3 is not
// beq or blt decodes as no branch.
module riscv_instruction_decoder_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [rvid_pkg::InstrWidth-1:0]       instruction,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  operand_one_is_pc,
  output logic                                  operand_two_is_imm,
  output logic [2:0]                            imm_kind,
  output logic [1:0]                            alu_class,
  output logic                                  reads_registers,
  output logic                                  writes_register,
  output logic                                  reads_memory,
  output logic                                  writes_memory,
  output logic [1:0]                            branch_kind,
  output logic [1:0]                            jump_kind,
  output logic [3:0]                            alu_select,
  output logic signed [rvid_pkg::ImmWidth-1:0]  immediate
);
  import rvid_pkg::*;

  // Input stage
  logic                  in_stage_valid;
  logic [InstrWidth-1:0] in_stage_word;
  // Result stage
  logic                  res_valid;
  decode_t               res_word;

  logic    res_load;
  logic    in_advance;
  decode_t dec;

  // Result register takes a new word when empty or being drained this cycle.
  assign res_load   = !res_valid || out_ready;
  assign in_advance = in_stage_valid && res_load;
  // Accept a new request whenever the input stage is empty or moving on.
  assign in_ready   = !in_stage_valid || res_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_stage_valid <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (in_ready) begin
        in_stage_valid <= in_valid;
      end
      if (res_load) begin
        res_valid <= in_stage_valid;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_stage_word <= instruction;
    end
    if (in_advance) begin
      res_word <= dec;
    end
  end

  // Decode
  logic [4:0] op;
  logic [2:0] f3;
  logic       b25;
  logic [InstrWidth-1:0] w;

  assign w   = in_stage_word;
  assign op  = w[6:2];
  assign f3  = w[14:12];
  assign b25 = w[25];

  alu_select_t ialu_sel;

  // I-alu function table; also the fallback for unlisted R-type codes.
  always_comb begin
    case (f3)
      F3_ADD:  ialu_sel = ALU_ADD;
      F3_XOR:  ialu_sel = ALU_XOR;
      F3_OR:   ialu_sel = ALU_OR;
      F3_AND:  ialu_sel = ALU_AND;
      F3_SLL:  ialu_sel = ALU_SLL;
      default: ialu_sel = ALU_SR;
    endcase
  end

  always_comb begin
    dec = '0;

    unique case (op) inside
      OP_ALUR: begin
        dec.imm_kind  = IMM_NONE;
        dec.alu_class = CLASS_R;
      end
      OP_ALUI: begin
        dec.imm_kind  = IMM_I;
        dec.alu_class = CLASS_I;
      end
      OP_LOAD, OP_JALR: begin
        dec.imm_kind  = IMM_I;
        dec.alu_class = CLASS_ADD;
      end
      OP_STORE: begin
        dec.imm_kind  = IMM_S;
        dec.alu_class = CLASS_ADD;
      end
      OP_BRANCH: begin
        dec.imm_kind  = IMM_B;
        dec.alu_class = CLASS_SUB;
      end
      OP_JAL: begin
        dec.imm_kind  = IMM_J;
        dec.alu_class = CLASS_ADD;
      end
      default: begin
        // lui, auipc and anything unknown
        dec.imm_kind  = IMM_U;
        dec.alu_class = CLASS_ADD;
      end
    endcase

    dec.branch_kind = BR_NONE;
    if (op == OP_BRANCH) begin
      if (f3 == F3_BEQ) begin
        dec.branch_kind = BR_BEQ;
      end else if (f3 == F3_BLT) begin
        dec.branch_kind = BR_BLT;
      end
    end

    if (op == OP_JAL) begin
      dec.jump_kind = JMP_JAL;
    end else if (op == OP_JALR) begin
      dec.jump_kind = JMP_JALR;
    end else begin
      dec.jump_kind = JMP_NONE;
    end

    dec.operand_one_is_pc  = (op == OP_AUIPC);
    dec.operand_two_is_imm = !(op == OP_ALUR || op == OP_BRANCH ||
                               op == OP_JAL  || op == OP_JALR);
    dec.reads_registers    = !(op == OP_JAL || op == OP_LUI || op == OP_AUIPC);
    dec.writes_register    = !(op == OP_STORE || op == OP_BRANCH);
    dec.reads_memory       = (op == OP_LOAD);
    dec.writes_memory      = (op == OP_STORE);

    // ALU function
    case (dec.alu_class)
      CLASS_ADD: dec.alu_select = ALU_ADD;
      CLASS_SUB: dec.alu_select = ALU_SUB;
      CLASS_R: begin
        dec.alu_select = ialu_sel;
        if (!b25) begin
          case (f3)
            F3_ADD:  dec.alu_select = ALU_ADD;
            F3_SUB:  dec.alu_select = ALU_SUB;
            F3_XOR:  dec.alu_select = ALU_XOR;
            F3_OR:   dec.alu_select = ALU_OR;
            F3_AND:  dec.alu_select = ALU_AND;
            F3_SLL:  dec.alu_select = ALU_SLL;
            F3_SR:   dec.alu_select = ALU_SR;
            default: dec.alu_select = ialu_sel;
          endcase
        end else begin
          if (f3 == F3_REM) begin
            dec.alu_select = ALU_REM;
          end else if (f3 == F3_MUL) begin
            dec.alu_select = ALU_MUL;
          end else if (f3 == F3_DIV) begin
            dec.alu_select = ALU_DIV;
          end
        end
      end
      default: dec.alu_select = ialu_sel;
    endcase

    // Immediate
    unique case (dec.imm_kind)
      IMM_I:   dec.immediate = {{20{w[31]}}, w[31:20]};
      IMM_S:   dec.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
      IMM_B:   dec.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      IMM_J:   dec.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      IMM_U:   dec.immediate = {w[31:12], 12'b0};
      default: dec.immediate = ImmNone;
    endcase
  end

  // Drive outputs from the result register.
  assign out_valid          = res_valid;
  assign operand_one_is_pc  = res_word.operand_one_is_pc;
  assign operand_two_is_imm = res_word.operand_two_is_imm;
  assign imm_kind           = res_word.imm_kind;
  assign alu_class          = res_word.alu_class;
  assign reads_registers    = res_word.reads_registers;
  assign writes_register    = res_word.writes_register;
  assign reads_memory       = res_word.reads_memory;
  assign writes_memory      = res_word.writes_memory;
  assign branch_kind        = res_word.branch_kind;
  assign jump_kind          = res_word.jump_kind;
  assign alu_select         = res_word.alu_select;
  assign immediate          = res_word.immediate;

endmodule

### dv/control_word_checker.sv
module control_word_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_ready,
  input  logic [rvid_pkg::InstrWidth-1:0]       instruction,
  input  logic                                  out_valid,
  input  logic                                  out_ready,
  input  logic                                  operand_one_is_pc,
  input  logic                                  operand_two_is_imm,
  input  logic [2:0]                            imm_kind,
  input  logic [1:0]                            alu_class,
  input  logic                                  reads_registers,
  input  logic                                  writes_register,
  input  logic                                  reads_memory,
  input  logic                                  writes_memory,
  input  logic [1:0]                            branch_kind,
  input  logic [1:0]                            jump_kind,
  input  logic [3:0]                            alu_select,
  input  logic signed [rvid_pkg::ImmWidth-1:0]  immediate,
  output int unsigned                           mismatch_count,
  output int unsigned                           results_waiting,
  output int unsigned                           results_checked
);
  import rvid_pkg::*;

  decode_t expected_controls[$];

  // Decode one instruction word into its control word.
  function automatic decode_t predict_control(input logic [InstrWidth-1:0] word);
    decode_t    c;
    logic [4:0] opc;
    logic [2:0] f3;
    opc = word[6:2];
    f3  = word[14:12];
    c   = '0;

    c.operand_one_is_pc  = (opc == OP_AUIPC);
    c.operand_two_is_imm = !(opc == OP_ALUR || opc == OP_BRANCH ||
                             opc == OP_JAL || opc == OP_JALR);
    c.reads_registers    = !(opc == OP_JAL || opc == OP_LUI || opc == OP_AUIPC);
    c.writes_register    = !(opc == OP_STORE || opc == OP_BRANCH);
    c.reads_memory       = (opc == OP_LOAD);
    c.writes_memory      = (opc == OP_STORE);

    case (opc)
      OP_ALUR: begin
        c.imm_kind  = IMM_NONE;
        c.alu_class = CLASS_R;
      end
      OP_ALUI: begin
        c.imm_kind  = IMM_I;
        c.alu_class = CLASS_I;
      end
      OP_LOAD, OP_JALR: begin
        c.imm_kind  = IMM_I;
        c.alu_class = CLASS_ADD;
      end
      OP_STORE: begin
        c.imm_kind  = IMM_S;
        c.alu_class = CLASS_ADD;
      end
      OP_BRANCH: begin
        c.imm_kind  = IMM_B;
        c.alu_class = CLASS_SUB;
      end
      OP_JAL: begin
        c.imm_kind  = IMM_J;
        c.alu_class = CLASS_ADD;
      end
      default: begin
        c.imm_kind  = IMM_U;
        c.alu_class = CLASS_ADD;
      end
    endcase

    c.branch_kind = BR_NONE;
    if (opc == OP_BRANCH) begin
      if (f3 == F3_BEQ) c.branch_kind = BR_BEQ;
      else if (f3 == F3_BLT) c.branch_kind = BR_BLT;
    end

    c.jump_kind = JMP_NONE;
    if (opc == OP_JAL) c.jump_kind = JMP_JAL;
    else if (opc == OP_JALR) c.jump_kind = JMP_JALR;

    case (c.alu_class)
      CLASS_ADD: c.alu_select = ALU_ADD;
      CLASS_SUB: c.alu_select = ALU_SUB;
      default: begin
        // I-alu table; R-type codes without a match of their own land here too
        case (f3)
          F3_ADD:  c.alu_select = ALU_ADD;
          F3_XOR:  c.alu_select = ALU_XOR;
          F3_OR:   c.alu_select = ALU_OR;
          F3_AND:  c.alu_select = ALU_AND;
          F3_SLL:  c.alu_select = ALU_SLL;
          default: c.alu_select = ALU_SR;
        endcase
        if (c.alu_class == CLASS_R) begin
          if (!word[25]) begin
            case (f3)
              F3_SUB: c.alu_select = ALU_SUB;
              F3_SR:  c.alu_select = ALU_SR;
              default: ;
            endcase
          end else begin
            case (f3)
              F3_MUL: c.alu_select = ALU_MUL;
              F3_DIV: c.alu_select = ALU_DIV;
              F3_REM: c.alu_select = ALU_REM;
              default: ;
            endcase
          end
        end
      end
    endcase

    case (c.imm_kind)
      IMM_I:   c.immediate = {{20{word[31]}}, word[31:20]};
      IMM_S:   c.immediate = {{20{word[31]}}, word[31:25], word[11:7]};
      IMM_B:   c.immediate = {{19{word[31]}}, word[31], word[7], word[30:25],
                              word[11:8], 1'b0};
      IMM_J:   c.immediate = {{11{word[31]}}, word[31], word[19:12], word[20],
                              word[30:21], 1'b0};
      IMM_U:   c.immediate = {word[31:12], 12'h000};
      default: c.immediate = ImmNone;
    endcase
    return c;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got, inout int errs);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    decode_t want;
    int      errs;
    errs = 0;
    if (rst) begin
      expected_controls.delete();
    end else begin
      if (in_valid && in_ready)
        expected_controls.insert(expected_controls.size(), predict_control(instruction));
      if (out_valid && out_ready) begin
        if (expected_controls.size() == 0) begin
          $error("result with no request outstanding");
          errs++;
        end else begin
          want = expected_controls.pop_front();
          check_field("operand_one_is_pc", 32'(want.operand_one_is_pc),
                      32'(operand_one_is_pc), errs);
          check_field("operand_two_is_imm", 32'(want.operand_two_is_imm),
                      32'(operand_two_is_imm), errs);
          check_field("imm_kind", 32'(want.imm_kind), 32'(imm_kind), errs);
          check_field("alu_class", 32'(want.alu_class), 32'(alu_class), errs);
          check_field("reads_registers", 32'(want.reads_registers),
                      32'(reads_registers), errs);
          check_field("writes_register", 32'(want.writes_register),
                      32'(writes_register), errs);
          check_field("reads_memory", 32'(want.reads_memory), 32'(reads_memory), errs);
          check_field("writes_memory", 32'(want.writes_memory), 32'(writes_memory), errs);
          check_field("branch_kind", 32'(want.branch_kind), 32'(branch_kind), errs);
          check_field("jump_kind", 32'(want.jump_kind), 32'(jump_kind), errs);
          check_field("alu_select", 32'(want.alu_select), 32'(alu_select), errs);
          check_field("immediate", want.immediate, immediate, errs);
          results_checked <= results_checked + 1;
        end
      end
    end
    mismatch_count  <= mismatch_count + errs;
    results_waiting <= expected_controls.size();
  end

endmodule

### dv/tb_riscv_instruction_decoder_unit.sv
module tb_riscv_instruction_decoder_unit;
  import rvid_pkg::*;

  localparam int unsigned RandomRequests = 800;
  localparam int unsigned HoldOffAt      = 200;  // random request that starts the long hold-off
  localparam int unsigned DrainAt        = 420;  // random request before which the sender drains
  localparam int unsigned QuietFrom      = 680;  // no idling from here on
  localparam int unsigned HoldCycles     = 64;
  localparam int unsigned WatchdogLimit  = 1000;
  localparam logic [4:0]  OpMiscMem      = 5'b00011;  // opcode outside the supported set

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Request side
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [InstrWidth-1:0] instruction = '0;

  // Result side
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic                       operand_one_is_pc;
  logic                       operand_two_is_imm;
  logic [2:0]                 imm_kind;
  logic [1:0]                 alu_class;
  logic                       reads_registers;
  logic                       writes_register;
  logic                       reads_memory;
  logic                       writes_memory;
  logic [1:0]                 branch_kind;
  logic [1:0]                 jump_kind;
  logic [3:0]                 alu_select;
  logic signed [ImmWidth-1:0] immediate;

  int unsigned mismatch_count;
  int unsigned results_waiting;
  int unsigned results_checked;

  // Flags shared between the sender and the receiver, then run counters
  logic        quiet        = 1'b0;  // suppress all idling near the end
  logic        hold_results = 1'b0;  // ask the receiver for one long hold-off
  int unsigned requests_sent = 0;
  int unsigned directed_sent = 0;
  int unsigned idle_cycles   = 0;

  always #5 clk = ~clk;

  riscv_instruction_decoder_unit uut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .instruction        (instruction),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .operand_one_is_pc  (operand_one_is_pc),
    .operand_two_is_imm (operand_two_is_imm),
    .imm_kind           (imm_kind),
    .alu_class          (alu_class),
    .reads_registers    (reads_registers),
    .writes_register    (writes_register),
    .reads_memory       (reads_memory),
    .writes_memory      (writes_memory),
    .branch_kind        (branch_kind),
    .jump_kind          (jump_kind),
    .alu_select         (alu_select),
    .immediate          (immediate)
  );

  control_word_checker control_check (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .instruction        (instruction),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .operand_one_is_pc  (operand_one_is_pc),
    .operand_two_is_imm (operand_two_is_imm),
    .imm_kind           (imm_kind),
    .alu_class          (alu_class),
    .reads_registers    (reads_registers),
    .writes_register    (writes_register),
    .reads_memory       (reads_memory),
    .writes_memory      (writes_memory),
    .branch_kind        (branch_kind),
    .jump_kind          (jump_kind),
    .alu_select         (alu_select),
    .immediate          (immediate),
    .mismatch_count     (mismatch_count),
    .results_waiting    (results_waiting),
    .results_checked    (results_checked)
  );

  // Hold reset at the start, then release it for good.
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // Overlay opcode, funct3 and bit 25 onto an arbitrary fill pattern.
  function automatic logic [InstrWidth-1:0] encode_word(input logic [4:0] opc,
                                                        input logic [2:0] f3,
                                                        input logic b25,
                                                        input logic [InstrWidth-1:0] fill);
    logic [InstrWidth-1:0] word;
    word        = fill;
    word[6:2]   = opc;
    word[14:12] = f3;
    word[25]    = b25;
    return word;
  endfunction

  // Offer one request and hold it until accepted. An optional idle burst
  // drops valid first; otherwise valid stays high straight into the next
  // request, so valid gets a single assignment per edge.
  task automatic send_request(input logic [InstrWidth-1:0] word);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    instruction <= word;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Drop valid and wait until every outstanding request has its result.
  // The first edge lets the checker's count catch up with the last accept.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_waiting != 0) @(posedge clk);
  endtask

  // Stimulus: directed corner cases, then random traffic.
  initial begin : stimulus
    logic [InstrWidth-1:0] directed_words[$];
    logic [4:0]            major_ops[9];
    logic [InstrWidth-1:0] word;

    major_ops = '{OP_LOAD, OP_ALUI, OP_AUIPC, OP_STORE, OP_ALUR,
                  OP_LUI, OP_BRANCH, OP_JALR, OP_JAL};

    // All-zero word (load, zero immediate) and all-ones word (unknown opcode).
    directed_words = {directed_words, 32'h0000_0000};
    directed_words = {directed_words, 32'hFFFF_FFFF};
    // R-type: every funct3 without bit 25, then mul, div, rem and a
    // bit-25 code that falls through to the I-alu table.
    for (int i = 0; i < 8; i++)
      directed_words = {directed_words, encode_word(OP_ALUR, 3'(i), 1'b0, 32'h0000_0033)};
    directed_words = {directed_words, encode_word(OP_ALUR, F3_MUL, 1'b1, 32'h0000_0033)};
    directed_words = {directed_words, encode_word(OP_ALUR, F3_DIV, 1'b1, 32'h0000_0033)};
    directed_words = {directed_words, encode_word(OP_ALUR, F3_REM, 1'b1, 32'h0000_0033)};
    directed_words = {directed_words, encode_word(OP_ALUR, F3_AND, 1'b1, 32'h0000_0033)};
    // Immediate extremes for each format.
    directed_words = {directed_words, encode_word(OP_ALUI, F3_SR, 1'b1, 32'hFFFF_FFFF)};
    directed_words = {directed_words, encode_word(OP_STORE, F3_SUB, 1'b0, 32'h8000_0003)};
    directed_words = {directed_words, encode_word(OP_BRANCH, F3_BEQ, 1'b0, 32'h8000_0083)};
    directed_words = {directed_words, encode_word(OP_BRANCH, F3_BLT, 1'b1, 32'h7E00_0F03)};
    // Branch with a funct3 that is neither beq nor blt.
    directed_words = {directed_words, encode_word(OP_BRANCH, F3_OR, 1'b0, 32'hFFFF_FFFF)};
    directed_words = {directed_words, encode_word(OP_JAL, F3_AND, 1'b0, 32'h8000_0003)};
    directed_words = {directed_words, encode_word(OP_JALR, F3_ADD, 1'b1, 32'h7FF0_0003)};
    directed_words = {directed_words, encode_word(OP_LUI, F3_AND, 1'b1, 32'hFFFF_FFFF)};
    directed_words = {directed_words, encode_word(OP_AUIPC, F3_ADD, 1'b0, 32'h0000_1003)};
    directed_words = {directed_words, encode_word(OpMiscMem, F3_XOR, 1'b0, 32'h1234_5603)};

    // Wait for reset to drop.
    do @(posedge clk); while (rst);

    foreach (directed_words[i]) send_request(directed_words[i]);
    directed_sent = requests_sent;

    for (int unsigned n = 0; n < RandomRequests; n++) begin
      if (n == HoldOffAt) hold_results <= 1'b1;  // keep offering while results back up
      if (n == DrainAt) drain_results();
      if (n == QuietFrom) quiet <= 1'b1;
      // Mostly supported opcodes with random fields; the rest pure noise.
      if ($urandom_range(0, 3) != 0)
        word = encode_word(major_ops[$urandom_range(0, 8)], 3'($urandom),
                           1'($urandom), $urandom);
      else
        word = $urandom;
      send_request(word);
    end

    drain_results();
    repeat (8) @(posedge clk);

    $display("covered %0d instruction words (%0d directed, %0d random) over all opcodes",
             requests_sent, directed_sent, requests_sent - directed_sent);
    $display("checked %0d control words under random stalls, a %0d-cycle hold-off and a drain",
             results_checked, HoldCycles);
    if (mismatch_count == 0 && results_waiting == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Receiver: random ready bursts, one long hold-off on request, and
  // ready held high once the run goes quiet.
  initial begin : receiver
    logic hold_done;
    hold_done = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_results && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
